### design/vstr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voigt tensor rotation package
// Widths, register indexes, reset values and Voigt index tables shared by the
// rotation datapath, its stream interfaces and its checker.
// ----------------------------------------------------------------------------
package vstr_pkg;

  localparam int ROT_W     = 18;               // signed Q1.16 rotation entry
  localparam int IN_W      = 32;               // signed Q16.16 tensor component
  localparam int OUT_W     = 36;               // signed Q20.16 result
  localparam int VN        = 6;                // Voigt components
  localparam int NROW      = 3;                // rows and columns of rotation
  localparam int CFG_W     = NROW * ROT_W;     // one packed rotation row
  localparam int CFG_IDX_W = 2;

  localparam int FRAC_SH = 16;
  localparam int V_W     = 2 * ROT_W + 1;      // Voigt matrix entry, Q.32
  localparam int XH_W    = IN_W - FRAC_SH;     // signed upper half of a component
  localparam int XL_W    = FRAC_SH + 1;        // lower half, zero extended
  localparam int PH_W    = V_W + XH_W;
  localparam int PL_W    = V_W + XL_W;
  localparam int HI_W    = PH_W + 3;           // sum of six products
  localparam int LO_W    = PL_W + 3;
  localparam int ACC_W   = LO_W;
  localparam int R_W     = ACC_W - FRAC_SH;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE = 2'd2;

  localparam logic [CFG_W-1:0] ROW_ONE_RST   = 54'd65536;
  localparam logic [CFG_W-1:0] ROW_TWO_RST   = 54'd17179869184;
  localparam logic [CFG_W-1:0] ROW_THREE_RST = 54'd4503599627370496;

  typedef logic signed [IN_W-1:0]  in_word_t;
  typedef logic signed [OUT_W-1:0] out_word_t;
  typedef logic signed [ROT_W-1:0] rot_entry_t;
  typedef logic signed [V_W-1:0]   v_entry_t;

  localparam out_word_t OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam out_word_t OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Row and column of each Voigt component: 11, 22, 33, 12, 23, 13.
  localparam int PAIR_A [VN] = '{0, 1, 2, 0, 1, 0};
  localparam int PAIR_B [VN] = '{0, 1, 2, 1, 2, 2};

endpackage

### design/vstr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voigt tensor stream interfaces
// Valid/ready channels for input tensor words and rotated result words.
// ----------------------------------------------------------------------------
interface vstr_in_if
  import vstr_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_word_t in_xx;
  in_word_t in_yy;
  in_word_t in_zz;
  in_word_t in_xy;
  in_word_t in_yz;
  in_word_t in_xz;

  modport source (output valid, in_xx, in_yy, in_zz, in_xy, in_yz, in_xz, input ready);
  modport sink   (input valid, in_xx, in_yy, in_zz, in_xy, in_yz, in_xz, output ready);
endinterface

interface vstr_out_if
  import vstr_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_word_t out_xx;
  out_word_t out_yy;
  out_word_t out_zz;
  out_word_t out_xy;
  out_word_t out_yz;
  out_word_t out_xz;

  modport source (output valid, out_xx, out_yy, out_zz, out_xy, out_yz, out_xz, input ready);
  modport sink   (input valid, out_xx, out_yy, out_zz, out_xy, out_yz, out_xz, output ready);
endinterface

### design/voigt_symmetric_tensor_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voigt symmetric tensor rotation
// Throughput: one word per cycle when nothing downstream stalls. The rate
// is set by the four-register pipeline (input, products, sums, output);
// every stage holds its own valid bit and fills bubbles on a stall.
// Reset is synchronous and active low: it empties the pipeline and loads the
// identity rotation. The Voigt matrix is registered and follows the rotation
// in the cycle after it.
// ----------------------------------------------------------------------------
module voigt_symmetric_tensor_rotation
  import vstr_pkg::*;
  (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  vstr_in_if.sink              in_ch,
  vstr_out_if.source           out_ch
  );

  // Rotation registers and the derived 6x6 Voigt matrix.
  logic [CFG_W-1:0]  rot_r [NROW];
  rot_entry_t        rot_e [NROW][NROW];
  v_entry_t          v_nxt [VN][VN];
  v_entry_t          v_r   [VN][VN];

  // Pipeline stage valid bits and stage-ready terms.
  logic s0_valid_r, s1_valid_r, s2_valid_r, s3_valid_r;
  logic s0_ready, s1_ready, s2_ready, s3_ready;

  // Stage payloads.
  in_word_t                  x_in  [VN];
  in_word_t                  x_r   [VN];
  logic signed [XH_W-1:0]    xh    [VN];
  logic signed [XL_W-1:0]    xl    [VN];
  logic signed [PH_W-1:0]    ph_nxt [VN][VN];
  logic signed [PL_W-1:0]    pl_nxt [VN][VN];
  logic signed [PH_W-1:0]    ph_r   [VN][VN];
  logic signed [PL_W-1:0]    pl_r   [VN][VN];
  logic signed [HI_W-1:0]    hi_nxt [VN];
  logic signed [LO_W-1:0]    lo_nxt [VN];
  logic signed [HI_W-1:0]    hi_r   [VN];
  logic signed [LO_W-1:0]    lo_r   [VN];
  out_word_t                 y_nxt  [VN];
  out_word_t                 y_r    [VN];

  // --------------------------------------------------------------------------
  // Configuration. Writes to an index past the last row are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= ROW_ONE_RST;
      rot_r[1] <= ROW_TWO_RST;
      rot_r[2] <= ROW_THREE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROW_ONE:   rot_r[0] <= cfg_data;
        REG_ROW_TWO:   rot_r[1] <= cfg_data;
        REG_ROW_THREE: rot_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Column one sits in the low bits of each row register.
  for (genvar gr = 0; gr < NROW; gr++) begin : g_row
    for (genvar gc = 0; gc < NROW; gc++) begin : g_col
      assign rot_e[gr][gc] = $signed(rot_r[gr][gc*ROT_W +: ROT_W]);
    end
  end

  // Voigt matrix entry (i, j): with (p,q) the pair of row i and (s,t) the
  // pair of column j, it is R_ps*R_qs on the diagonal columns and
  // R_ps*R_qt + R_pt*R_qs on the shear columns. It is rebuilt every cycle,
  // so it is settled in the cycle after a configuration write, before a word
  // accepted after that write reaches the product stage.
  for (genvar gi = 0; gi < VN; gi++) begin : g_vrow
    for (genvar gj = 0; gj < VN; gj++) begin : g_vcol
      localparam int P = PAIR_A[gi];
      localparam int Q = PAIR_B[gi];
      localparam int S = PAIR_A[gj];
      localparam int T = PAIR_B[gj];
      logic signed [2*ROT_W-1:0] prod_a;
      assign prod_a = rot_e[P][S] * rot_e[Q][T];
      if (S == T) begin : g_diag
        assign v_nxt[gi][gj] = V_W'(prod_a);
      end else begin : g_shear
        logic signed [2*ROT_W-1:0] prod_b;
        assign prod_b = rot_e[P][T] * rot_e[Q][S];
        assign v_nxt[gi][gj] = V_W'(prod_a) + V_W'(prod_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  // --------------------------------------------------------------------------
  // Handshake. A stage takes a new word when it is empty or when the stage
  // after it moves, so bubbles collapse while the output word waits.
  // --------------------------------------------------------------------------
  assign s3_ready = !s3_valid_r || out_ch.ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s0_ready = !s0_valid_r || s1_ready;

  assign in_ch.ready = rst_n && s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_r <= in_ch.valid;
      end
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  assign x_in[0] = in_ch.in_xx;
  assign x_in[1] = in_ch.in_yy;
  assign x_in[2] = in_ch.in_zz;
  assign x_in[3] = in_ch.in_xy;
  assign x_in[4] = in_ch.in_yz;
  assign x_in[5] = in_ch.in_xz;

  always_ff @(posedge clk) begin
    if (s0_ready && in_ch.valid) begin
      x_r <= x_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: products. Each component is split into a signed upper half and
  // an unsigned lower half so that every multiplier stays near 37x17 bits;
  // the two partial products together are exact.
  // --------------------------------------------------------------------------
  for (genvar gk = 0; gk < VN; gk++) begin : g_split
    assign xh[gk] = $signed(x_r[gk][IN_W-1 -: XH_W]);
    assign xl[gk] = $signed({1'b0, x_r[gk][FRAC_SH-1:0]});
  end

  for (genvar gi = 0; gi < VN; gi++) begin : g_prow
    for (genvar gj = 0; gj < VN; gj++) begin : g_pcol
      assign ph_nxt[gi][gj] = v_r[gi][gj] * xh[gj];
      assign pl_nxt[gi][gj] = v_r[gi][gj] * xl[gj];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s0_valid_r) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: per-row sums of the upper and the lower partial products.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < VN; i++) begin
      hi_nxt[i] = '0;
      lo_nxt[i] = '0;
      for (int j = 0; j < VN; j++) begin
        hi_nxt[i] = hi_nxt[i] + HI_W'(ph_r[i][j]);
        lo_nxt[i] = lo_nxt[i] + LO_W'(pl_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: the exact sum is hi * 2^16 + lo. Flooring it by 2^32 equals
  // flooring (hi + floor(lo / 2^16)) by 2^16. The result then saturates to
  // the 36-bit output range.
  // --------------------------------------------------------------------------
  for (genvar gi = 0; gi < VN; gi++) begin : g_out
    logic signed [ACC_W-1:0] acc;
    logic [R_W-1:0]          rr;
    logic                    in_range;
    assign acc      = ACC_W'(hi_r[gi]) + ACC_W'(lo_r[gi] >>> FRAC_SH);
    assign rr       = acc[ACC_W-1:FRAC_SH];
    assign in_range = (&rr[R_W-1:OUT_W-1]) || !(|rr[R_W-1:OUT_W-1]);
    assign y_nxt[gi] = in_range ? $signed(rr[OUT_W-1:0])
                                : (rr[R_W-1] ? OUT_MIN : OUT_MAX);
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      y_r <= y_nxt;
    end
  end

  assign out_ch.valid  = s3_valid_r;
  assign out_ch.out_xx = y_r[0];
  assign out_ch.out_yy = y_r[1];
  assign out_ch.out_zz = y_r[2];
  assign out_ch.out_xy = y_r[3];
  assign out_ch.out_yz = y_r[4];
  assign out_ch.out_xz = y_r[5];

endmodule

### design/vstr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voigt tensor rotation checker
// Port-level assertions on reset, flow and stall behavior of the rotation.
// ----------------------------------------------------------------------------
module vstr_checker
  import vstr_pkg::*;
  (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_xx,
  input out_word_t out_yy,
  input out_word_t out_zz,
  input out_word_t out_xy,
  input out_word_t out_yz,
  input out_word_t out_xz
  );

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // Input back-pressure only comes from a full pipeline behind a stalled output.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled although the output is moving");

  // A word accepted into a free-flowing pipeline comes out at the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted word did not reach the output in time");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_xx) && $stable(out_yy)
      && $stable(out_zz) && $stable(out_xy) && $stable(out_yz) && $stable(out_xz)))
    else $error("stalled output word changed");

endmodule

bind voigt_symmetric_tensor_rotation vstr_checker u_vstr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_xx    (out_ch.out_xx),
  .out_yy    (out_ch.out_yy),
  .out_zz    (out_ch.out_zz),
  .out_xy    (out_ch.out_xy),
  .out_yz    (out_ch.out_yz),
  .out_xz    (out_ch.out_xz)
);
